[design/sc_pkg.sv]
// ----------------------------------------------------------------------------
// sc_pkg
// Shared types and constants for the stack calculator execute unit.
// ----------------------------------------------------------------------------
package sc_pkg;

    // Default sizes of the stack and of one stack entry.
    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed port field widths.
    localparam int KIND_W   = 3;
    localparam int LIT_W    = 32;
    localparam int TOP_W    = 32;
    localparam int DEPTH_W  = 8;
    localparam int STATUS_W = 2;

    // Instruction codes carried by the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 3'd0,
        KIND_ADD  = 3'd1,
        KIND_SUB  = 3'd2,
        KIND_MULT = 3'd3,
        KIND_DIV  = 3'd4
    } kind_t;

    // Status codes returned with each result item.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIV_ZERO  = 2'd3
    } status_t;

    // Command from the sequencer to the serial arithmetic unit.
    typedef struct packed {
        logic  start;
        kind_t op;
    } arith_cmd_t;

endpackage

[design/sc_stack.sv]
// ----------------------------------------------------------------------------
// sc_stack
// Stack storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sc_stack
    import sc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    localparam int AW         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sc_arith.sv]
// ----------------------------------------------------------------------------
// sc_arith
// Serial arithmetic unit. Add and subtract run one bit per cycle through a
// serial adder, multiply takes one multiplier bit per cycle (shift and add),
// and divide produces one quotient bit per cycle (restoring division).
// ----------------------------------------------------------------------------
module sc_arith
    import sc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  arith_cmd_t            cmd,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_RUN  = 3'b010,
        A_FIN  = 3'b100
    } astate_t;

    astate_t       state_reg, state_next;
    kind_t         op_reg, op_next;
    logic [W-1:0]  sa_reg, sa_next;
    logic [W-1:0]  sb_reg, sb_next;
    logic [W-1:0]  res_reg, res_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic          carry_reg, carry_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic          sum_bit;
    logic [W:0]    shifted;
    logic [W+1:0]  diff;
    logic          ge;

    // One serial step of the add, subtract and divide operations.
    always_comb begin
        sum_bit = sa_reg[0] ^ sb_reg[0] ^ carry_reg;
        shifted = {rem_reg, sa_reg[W-1]};
        diff    = {1'b0, shifted} - {2'b00, sb_reg};
        ge      = ~diff[W+1];
    end

    // Sequencing of the serial steps.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        res_next   = res_reg;
        rem_next   = rem_reg;
        carry_next = carry_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (cmd.start) begin
                    state_next = A_RUN;
                    op_next    = cmd.op;
                    cnt_next   = '0;
                    res_next   = '0;
                    rem_next   = '0;
                    carry_next = (cmd.op == KIND_SUB);
                    neg_next   = op_a[W-1] ^ op_b[W-1];
                    sa_next    = op_a;
                    sb_next    = op_b;
                    unique case (cmd.op)
                        KIND_SUB: begin
                            sb_next = ~op_b;
                        end
                        KIND_DIV: begin
                            sa_next = op_a[W-1] ? (W'(0) - op_a) : op_a;
                            sb_next = op_b[W-1] ? (W'(0) - op_b) : op_b;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            A_RUN: begin
                unique case (op_reg)
                    KIND_ADD, KIND_SUB: begin
                        res_next   = {sum_bit, res_reg[W-1:1]};
                        carry_next = (sa_reg[0] & sb_reg[0]) | (sa_reg[0] & carry_reg)
                                   | (sb_reg[0] & carry_reg);
                        sa_next    = {1'b0, sa_reg[W-1:1]};
                        sb_next    = {1'b0, sb_reg[W-1:1]};
                    end
                    KIND_MULT: begin
                        res_next = res_reg + (sb_reg[0] ? sa_reg : '0);
                        sa_next  = {sa_reg[W-2:0], 1'b0};
                        sb_next  = {1'b0, sb_reg[W-1:1]};
                    end
                    default: begin
                        rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
                        sa_next  = {sa_reg[W-2:0], ge};
                    end
                endcase
                if (cnt_reg == CW'(W - 1)) begin
                    state_next = A_FIN;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            A_FIN: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        res_reg   <= res_next;
        rem_reg   <= rem_next;
        carry_reg <= carry_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
    end

    // The quotient takes its sign in the final cycle.
    assign done   = (state_reg == A_FIN);
    assign result = (op_reg == KIND_DIV) ? (neg_reg ? (W'(0) - sa_reg) : sa_reg) : res_reg;

endmodule

[design/stack_calculator_alu.sv]
// ----------------------------------------------------------------------------
// stack_calculator_alu
// Execute unit of a stack machine: push, add, subtract, multiply, divide.
// ----------------------------------------------------------------------------
// One item is one instruction, and each item returns one result item with the
// new top of stack, the depth and a status. Items are handled one at a time.
// A push, an underflow, an overflow or an unused code goes from decode straight
// to the response state, which loads the output register when it is free. A
// division by zero takes one cycle more, since the divisor has to be read from
// the stack memory first. An arithmetic item passes through decode, which reads
// the second entry from the stack memory, a load state, which starts the serial
// arithmetic unit with that entry, and an execute state, in which the unit
// handles one bit of the operands (add, subtract), of the multiplier or of the
// quotient per cycle and then signals completion; the result is written back
// in the same cycle as completion, and the response state then loads the
// output register. The top of stack is held in a register, so each operation
// reads the memory once. A new item is taken while the previous result still
// waits on the output; the next result then waits until the output is free,
// and the input stalls meanwhile.
// ----------------------------------------------------------------------------
module stack_calculator_alu
    import sc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic signed [LIT_W-1:0]    s_literal,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [TOP_W-1:0]    m_top_value,
    output logic [DEPTH_W-1:0]         m_depth,
    output logic [STATUS_W-1:0]        m_status
);

    localparam int W   = DATA_WIDTH;
    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_LOAD   = 5'b00100,
        S_EXEC   = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [W-1:0]         lit_reg, lit_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    logic [W-1:0]         top_reg, top_next;
    status_t              status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TOP_W-1:0]     m_top_value_reg, m_top_value_next;
    logic [DEPTH_W-1:0]   m_depth_reg, m_depth_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [W-1:0]         wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [W-1:0]         rd_data;
    arith_cmd_t           cmd;
    logic                 arith_done;
    logic [W-1:0]         arith_result;
    logic [AW-1:0]        second_addr;
    logic                 out_free;

    // Stack storage.
    sc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Serial arithmetic: operand a is the top, operand b the entry below it.
    sc_arith #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op_a    (top_reg),
        .op_b    (rd_data),
        .done    (arith_done),
        .result  (arith_result)
    );

    assign second_addr = AW'(sp_reg - SPW'(2));
    assign rd_addr     = second_addr;
    assign rd_en       = (state_reg == S_DECODE);
    assign out_free    = !m_valid_reg || m_ready;

    // Instruction sequencer.
    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        lit_next         = lit_reg;
        sp_next          = sp_reg;
        top_next         = top_reg;
        status_next      = status_reg;
        m_top_value_next = m_top_value_reg;
        m_depth_next     = m_depth_reg;
        m_status_next    = m_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        wr_en            = 1'b0;
        wr_addr          = second_addr;
        wr_data          = arith_result;
        cmd.start        = 1'b0;
        cmd.op           = kind_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = kind_t'(s_kind);
                    lit_next   = W'(s_literal);
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = ST_OK;
                state_next  = S_RESP;
                unique case (kind_reg)
                    KIND_PUSH: begin
                        if (sp_reg >= SPW'(STACK_DEPTH)) begin
                            status_next = ST_OVERFLOW;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = AW'(sp_reg);
                            wr_data  = lit_reg;
                            top_next = lit_reg;
                            sp_next  = sp_reg + SPW'(1);
                        end
                    end
                    KIND_ADD, KIND_SUB, KIND_MULT, KIND_DIV: begin
                        if (sp_reg < SPW'(2)) begin
                            status_next = ST_UNDERFLOW;
                        end else begin
                            state_next = S_LOAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_LOAD: begin
                // The second entry is now on the read port.
                if (kind_reg == KIND_DIV && rd_data == '0) begin
                    status_next = ST_DIV_ZERO;
                    state_next  = S_RESP;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (arith_done) begin
                    wr_en      = 1'b1;
                    top_next   = arith_result;
                    sp_next    = sp_reg - SPW'(1);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_top_value_next = (sp_reg != '0) ? TOP_W'(top_reg) : '0;
                    m_depth_next     = DEPTH_W'(sp_reg);
                    m_status_next    = status_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        lit_reg         <= lit_next;
        top_reg         <= top_next;
        status_reg      <= status_next;
        m_top_value_reg <= m_top_value_next;
        m_depth_reg     <= m_depth_next;
        m_status_reg    <= m_status_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_top_value = m_top_value_reg;
    assign m_depth     = m_depth_reg;
    assign m_status    = m_status_reg;

endmodule
